// ----- hdl/line_time_piecewise_interp_defines.svh -----
// Assertion macros for the line/time interpolator
`ifndef LINE_TIME_PIECEWISE_INTERP_DEFINES_SVH
`define LINE_TIME_PIECEWISE_INTERP_DEFINES_SVH

// Property that must hold on every clock edge out of reset
`define LTPI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold in the cycle after its trigger
`define LTPI_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/ltpi_pkg.sv -----
package ltpi_pkg;

  localparam int unsigned MaxEntriesDef = 256;

  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncClear = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  localparam logic [2:0] StatOk    = 3'd0;
  localparam logic [2:0] StatFull  = 3'd1;
  localparam logic [2:0] StatOrder = 3'd2;
  localparam logic [2:0] StatShort = 3'd3;
  localparam logic [2:0] StatSat   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] line_pos;
    logic signed [63:0] entry_time;
  } req_t;

  typedef struct packed {
    logic signed [63:0] time_out;
    logic [2:0]         status;
    logic [7:0]         segment_used;
  } rsp_t;

  // 128-bit signed value saturated to 64 bits
  function automatic logic [64:0] sat128(input logic [127:0] a);
    logic [64:0] r;
    if (a[127:63] == {65{a[63]}}) r = {1'b0, a[63:0]};
    else if (a[127]) r = {1'b1, 64'h8000_0000_0000_0000};
    else r = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
    return r;
  endfunction

endpackage

// ----- hdl/ltpi_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle: 128 / 32
module ltpi_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] dividend_i,
  input  logic [31:0]  divisor_i,
  output logic         done_o,
  output logic [127:0] quot_o
);
  logic [127:0] quot_q, quot_d;
  logic [31:0]  rem_q, rem_d;
  logic [31:0]  dvs_q, dvs_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         run_q, run_d, done_q, done_d;
  logic [32:0]  trial;
  logic [33:0]  diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[127]};
    diff   = {1'b0, trial} - {2'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      // partial remainder stays below the divisor, so 32 bits hold it
      if (!diff[33]) begin
        rem_d  = diff[31:0];
        quot_d = {quot_q[126:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[126:0], 1'b0};
      end
      cnt_d = cnt_q + 8'd1;
      if (cnt_q == 8'd127) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- hdl/ltpi_table.sv -----
// Breakpoint table: synchronous memories holding {line, time} and slope per entry.
// Writes may target the slope of one row and the line/time of another, so
// line/time and slope live in two memories.
module ltpi_table #(
  parameter int unsigned MaxEntries = ltpi_pkg::MaxEntriesDef,
  parameter int unsigned IdxW = $clog2(MaxEntries)
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     raddr_i,
  output logic [31:0]         rline_o,
  output logic [63:0]         rtime_o,
  output logic [63:0]         rslope_o,
  input  logic                we_pt_i,
  input  logic [IdxW-1:0]     waddr_pt_i,
  input  logic [95:0]         wdata_pt_i,
  input  logic                we_s_i,
  input  logic [IdxW-1:0]     waddr_s_i,
  input  logic [63:0]         wdata_s_i
);
  logic [95:0] pt_mem [MaxEntries];
  logic [63:0] s_mem [MaxEntries];
  logic [95:0] pt_q;
  logic [63:0] s_q;

  always_ff @(posedge clk_i) begin
    if (we_pt_i) pt_mem[waddr_pt_i] <= wdata_pt_i;
    pt_q <= pt_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_s_i) s_mem[waddr_s_i] <= wdata_s_i;
    s_q <= s_mem[raddr_i];
  end

  assign rline_o  = pt_q[95:64];
  assign rtime_o  = pt_q[63:0];
  assign rslope_o = s_q;
endmodule

// ----- hdl/line_time_piecewise_interp.sv -----
// Flow from accept to result: clear, unused code, full table and short table go straight to the result;
// line not increasing ends after the previous row is read; a first load writes directly; other loads
// read the previous row and run the 128-step bit-serial divider; a query runs a binary search (one table
// read per probe), then a 64x32 multiply split over two 32x32 partial products.
// One item at a time; busy is high from accept through the result strobe, so the next item
// is accepted in the cycle after the strobe at the earliest. The receiver cannot stall.
// Reset: async active low, empty table, offset zero.
`include "line_time_piecewise_interp_defines.svh"

module line_time_piecewise_interp #(
  parameter int unsigned MaxEntries = ltpi_pkg::MaxEntriesDef,
  parameter int unsigned IdxW = $clog2(MaxEntries)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ltpi_pkg::req_t req_i,
  output logic          done_o,
  output ltpi_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i
);
  typedef enum logic [3:0] {
    SIdle, SLdRd, SLdWait, SLdDiv, SLdWr, SQStep, SQWait, SQEval,
    SQRd, SQWait2, SMul0, SMul1, SSum, SOut
  } state_e;

  localparam logic [IdxW:0] MaxCnt = (IdxW+1)'(MaxEntries);

  state_e          state_q;
  logic [IdxW:0]   cnt_q;
  logic [63:0]     offs_q;
  ltpi_pkg::req_t  req_q;
  ltpi_pkg::rsp_t  rsp_q;
  logic            done_q;
  logic [IdxW:0]   lo_q, hi_q;   // k in [lo, hi]
  logic [IdxW:0]   mid_q;
  logic [IdxW-1:0] seg_q;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rline;
  logic [63:0]     rtime, rslope;
  logic            neg_q, sat_q;
  logic [63:0]     smag_q, t_q;
  logic [31:0]     dmag_q;
  logic [63:0]     plo_q;
  logic [127:0]    acc_q;
  logic            div_start;
  logic            div_done;
  logic [127:0]    div_q;
  logic            we_pt, we_s;
  logic [63:0]     slope_w;
  logic [127:0]    dividend;
  logic [31:0]     dl;
  logic [127:0]    dt;
  logic [127:0]    dtmag;
  logic [64:0]     sr;
  logic [127:0]    qs;
  logic [32:0]     dx;
  logic [63:0]     pm0, pm1;
  logic [127:0]    prod, prod_s, sum;
  logic [64:0]     sum_sat;
  logic [IdxW:0]   kmax;

  // read address: search probe (held through the wait cycle) or chosen row
  always_comb begin
    raddr = seg_q;
    if (state_q == SQStep || state_q == SQWait) raddr = mid_q[IdxW-1:0];
  end

  ltpi_table #(.MaxEntries(MaxEntries), .IdxW(IdxW)) u_table (
    .clk_i, .raddr_i(raddr), .rline_o(rline), .rtime_o(rtime), .rslope_o(rslope),
    .we_pt_i(we_pt), .waddr_pt_i(cnt_q[IdxW-1:0]),
    .wdata_pt_i({req_q.line_pos, req_q.entry_time}),
    .we_s_i(we_s), .waddr_s_i(seg_q), .wdata_s_i(slope_w)
  );

  // slope numerator and denominator, valid in SLdWait onward (rline/rtime held)
  assign dl       = req_q.line_pos - rline;
  assign dt       = {{64{req_q.entry_time[63]}}, req_q.entry_time} -
                    {{64{rtime[63]}}, rtime};
  assign dtmag    = dt[127] ? (~dt + 128'd1) : dt;
  assign dividend = {dtmag[115:0], 12'd0};
  assign qs       = neg_q ? (~div_q + 128'd1) : div_q;
  assign sr       = ltpi_pkg::sat128(qs);
  assign slope_w  = sr[63:0];

  ltpi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dividend), .divisor_i(dl),
    .done_o(div_done), .quot_o(div_q)
  );

  assign div_start = (state_q == SLdWait);
  assign we_s  = (state_q == SLdWr) && cnt_q != '0;
  assign we_pt = (state_q == SLdWr);

  assign dx  = {req_q.line_pos[31], req_q.line_pos} - {rline[31], rline};
  assign pm0 = smag_q[31:0] * dmag_q;
  assign pm1 = smag_q[63:32] * dmag_q;
  assign prod   = {64'd0, plo_q} + {32'd0, pm1, 32'd0};
  assign prod_s = neg_q ? (~prod + 128'd1) : prod;
  assign sum = {{12{acc_q[127]}}, acc_q[127:12]} + {{64{offs_q[63]}}, offs_q} +
               {{64{t_q[63]}}, t_q};
  assign sum_sat = ltpi_pkg::sat128(sum);
  assign kmax = cnt_q - (IdxW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      offs_q  <= '0;
      done_q  <= 1'b0;
      req_q   <= '0;
      rsp_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      seg_q   <= '0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      smag_q  <= '0;
      dmag_q  <= '0;
      t_q     <= '0;
      plo_q   <= '0;
      acc_q   <= '0;
    end else begin
      done_q <= (state_q == SOut);
      if (cfg_we_i) offs_q <= cfg_wdata_i;
      unique case (state_q)
        SIdle: begin
          if (start && !busy) begin
            req_q <= req_i;
            rsp_q.time_out     <= '0;
            rsp_q.segment_used <= '0;
            unique case (req_i.func)
              ltpi_pkg::FuncLoad: begin
                if (cnt_q == MaxCnt) begin
                  rsp_q.status <= ltpi_pkg::StatFull;
                  state_q <= SOut;
                end else if (cnt_q == '0) begin
                  rsp_q.status <= ltpi_pkg::StatOk;
                  seg_q   <= '0;
                  state_q <= SLdWr;
                end else begin
                  rsp_q.status <= ltpi_pkg::StatOk;
                  seg_q   <= cnt_q[IdxW-1:0] - IdxW'(1);
                  state_q <= SLdRd;
                end
              end
              ltpi_pkg::FuncClear: begin
                rsp_q.status <= ltpi_pkg::StatOk;
                cnt_q   <= '0;
                state_q <= SOut;
              end
              ltpi_pkg::FuncQuery: begin
                if (cnt_q < (IdxW+1)'(2)) begin
                  rsp_q.status <= ltpi_pkg::StatShort;
                  state_q <= SOut;
                end else begin
                  rsp_q.status <= ltpi_pkg::StatOk;
                  lo_q    <= '0;
                  hi_q    <= kmax;
                  mid_q   <= kmax >> 1;
                  state_q <= SQStep;
                end
              end
              default: begin
                rsp_q.status <= ltpi_pkg::StatOk;
                state_q <= SOut;
              end
            endcase
          end
        end
        SLdRd: state_q <= SLdWait;
        SLdWait: begin
          if ($signed(rline) >= $signed(req_q.line_pos)) begin
            rsp_q.status <= ltpi_pkg::StatOrder;
            state_q <= SOut;
          end else begin
            neg_q   <= dt[127];
            state_q <= SLdDiv;
          end
        end
        SLdDiv: begin
          if (div_done) begin
            sat_q   <= sr[64];
            state_q <= SLdWr;
          end
        end
        SLdWr: begin
          cnt_q <= cnt_q + (IdxW+1)'(1);
          if (cnt_q != '0 && sat_q) rsp_q.status <= ltpi_pkg::StatSat;
          state_q <= SOut;
        end
        // binary search: k = number of entries j < cnt-1 with line_j < q
        SQStep: state_q <= SQWait;
        SQWait: state_q <= SQEval;
        SQEval: begin
          if (lo_q == hi_q) begin
            seg_q   <= (lo_q == '0) ? '0 : IdxW'(lo_q - (IdxW+1)'(1));
            state_q <= SQRd;
          end else begin
            if ($signed(rline) < $signed(req_q.line_pos)) begin
              lo_q  <= mid_q + (IdxW+1)'(1);
              mid_q <= (mid_q + (IdxW+1)'(1) + hi_q) >> 1;
            end else begin
              hi_q  <= mid_q;
              mid_q <= (lo_q + mid_q) >> 1;
            end
            state_q <= SQStep;
          end
        end
        SQRd: state_q <= SQWait2;
        SQWait2: begin
          neg_q  <= rslope[63] ^ dx[32];
          smag_q <= rslope[63] ? (~rslope + 64'd1) : rslope;
          dmag_q <= dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
          t_q    <= rtime;
          state_q <= SMul0;
        end
        SMul0: begin
          plo_q   <= pm0;
          state_q <= SMul1;
        end
        SMul1: begin
          acc_q   <= prod_s;
          state_q <= SSum;
        end
        SSum: begin
          rsp_q.time_out     <= sum_sat[63:0];
          rsp_q.status       <= sum_sat[64] ? ltpi_pkg::StatSat : ltpi_pkg::StatOk;
          rsp_q.segment_used <= 8'(seg_q);
          state_q <= SOut;
        end
        SOut: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy   = (state_q != SIdle) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `LTPI_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= MaxCnt, "entry count exceeds table")
  `LTPI_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "result strobe held")
  `LTPI_ASSERT(a_busy_done, clk_i, rst_ni, !done_q || busy, "strobe while not busy")
endmodule
